FILE: src/acia_pkg.sv
package acia_pkg;

  // Kind of request on the input channel
  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_RECEIVE = 1'b1
  } op_t;

  // Bus register addresses
  typedef enum logic [1:0] {
    REG_DATA    = 2'd0,
    REG_STATUS  = 2'd1,
    REG_COMMAND = 2'd2,
    REG_CONTROL = 2'd3
  } reg_sel_t;

  // Status register bit positions
  localparam int unsigned ST_PARITY  = 0;
  localparam int unsigned ST_FRAMING = 1;
  localparam int unsigned ST_OVERRUN = 2;
  localparam int unsigned ST_RXFULL  = 3;
  localparam int unsigned ST_TXEMPTY = 4;
  localparam int unsigned ST_IRQ     = 7;

  // Command register bit positions
  localparam int unsigned CM_DTR      = 0;
  localparam int unsigned CM_RXIRQOFF = 1;
  localparam int unsigned CM_TXCTL_LO = 2;
  localparam int unsigned CM_ECHO     = 4;

  // Transmit control code that enables the transmit interrupt
  localparam logic [1:0] TXCTL_IRQ_ON = 2'b01;

  localparam logic [7:0] STATUS_RESET = 8'h10;

  localparam int unsigned BAUD_W = 17;

  // One request as held in the input register
  typedef struct packed {
    logic [7:0] data;
    reg_sel_t   reg_select;
    op_t        op;
  } item_t;

  // One result as held in the output register
  typedef struct packed {
    logic [BAUD_W-1:0] baud_rate;
    logic              can_receive;
    logic              irq;
    logic [7:0]        rx_byte;
    logic [7:0]        status_now;
    logic [7:0]        tx_byte;
    logic              tx_valid;
  } result_t;

  // Baud rate selected by the low control nibble
  function automatic logic [BAUD_W-1:0] baud_lookup(input logic [3:0] sel);
    logic [BAUD_W-1:0] rate;
    unique case (sel)
      4'd0:    rate = 17'd115200;
      4'd1:    rate = 17'd50;
      4'd2:    rate = 17'd75;
      4'd3:    rate = 17'd110;
      4'd4:    rate = 17'd134;
      4'd5:    rate = 17'd150;
      4'd6:    rate = 17'd300;
      4'd7:    rate = 17'd600;
      4'd8:    rate = 17'd1200;
      4'd9:    rate = 17'd1800;
      4'd10:   rate = 17'd2400;
      4'd11:   rate = 17'd3600;
      4'd12:   rate = 17'd4800;
      4'd13:   rate = 17'd7200;
      4'd14:   rate = 17'd9600;
      default: rate = 17'd19200;
    endcase
    return rate;
  endfunction

endpackage

FILE: src/acia_core.sv
module acia_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  acia_pkg::item_t  item,
  output acia_pkg::result_t result
);

  logic [7:0] receive_hold_r, receive_hold_nxt;
  logic [7:0] status_r, status_nxt;
  logic [7:0] command_r, command_nxt;
  logic [7:0] control_r, control_nxt;

  logic       sent;
  logic [7:0] sent_byte;
  logic       recompute;
  logic       irq_on;

  // Register update for one request, then interrupt recomputation
  always_comb begin
    receive_hold_nxt = receive_hold_r;
    status_nxt       = status_r;
    command_nxt      = command_r;
    control_nxt      = control_r;
    sent             = 1'b0;
    sent_byte        = 8'h00;
    recompute        = 1'b0;

    if (item.op == acia_pkg::OP_WRITE) begin
      unique case (item.reg_select)
        acia_pkg::REG_DATA: begin
          sent                            = 1'b1;
          sent_byte                       = item.data;
          status_nxt[acia_pkg::ST_TXEMPTY] = 1'b1;
          recompute                       = 1'b1;
        end
        acia_pkg::REG_STATUS: begin
          // Programmed reset of the status flags
          status_nxt[acia_pkg::ST_IRQ]     = 1'b0;
          status_nxt[acia_pkg::ST_OVERRUN] = 1'b0;
          status_nxt[acia_pkg::ST_PARITY]  = 1'b0;
          status_nxt[acia_pkg::ST_FRAMING] = 1'b0;
          status_nxt[acia_pkg::ST_RXFULL]  = 1'b0;
          status_nxt[acia_pkg::ST_TXEMPTY] = 1'b1;
          recompute                        = 1'b1;
        end
        acia_pkg::REG_COMMAND: begin
          command_nxt = item.data;
          recompute   = 1'b1;
        end
        acia_pkg::REG_CONTROL: begin
          control_nxt = item.data;
        end
        default: begin
          control_nxt = control_r;
        end
      endcase
    end else if (command_r[acia_pkg::CM_DTR]) begin
      // A byte landing on a full receive register is an overrun
      if (status_r[acia_pkg::ST_RXFULL]) begin
        status_nxt[acia_pkg::ST_OVERRUN] = 1'b1;
      end
      receive_hold_nxt                = item.data;
      status_nxt[acia_pkg::ST_RXFULL] = 1'b1;
      if (command_r[acia_pkg::CM_ECHO]) begin
        sent      = 1'b1;
        sent_byte = item.data;
      end
      recompute = 1'b1;
    end

    irq_on = (status_nxt[acia_pkg::ST_RXFULL] && !command_nxt[acia_pkg::CM_RXIRQOFF]) ||
             (status_nxt[acia_pkg::ST_TXEMPTY] &&
              (command_nxt[acia_pkg::CM_TXCTL_LO +: 2] == acia_pkg::TXCTL_IRQ_ON));
    if (recompute) begin
      status_nxt[acia_pkg::ST_IRQ] = irq_on;
    end
  end

  // Result as seen after the request has taken effect
  always_comb begin
    result.tx_valid    = sent;
    result.tx_byte     = sent_byte;
    result.status_now  = status_nxt;
    result.rx_byte     = receive_hold_nxt;
    result.irq         = status_nxt[acia_pkg::ST_IRQ];
    result.can_receive = command_nxt[acia_pkg::CM_DTR] && !status_nxt[acia_pkg::ST_RXFULL];
    result.baud_rate   = acia_pkg::baud_lookup(control_nxt[3:0]);
  end

  // Architectural registers, committed when the request moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receive_hold_r <= 8'h00;
      status_r       <= acia_pkg::STATUS_RESET;
      command_r      <= 8'h00;
      control_r      <= 8'h00;
    end else if (step_en) begin
      receive_hold_r <= receive_hold_nxt;
      status_r       <= status_nxt;
      command_r      <= command_nxt;
      control_r      <= control_nxt;
    end
  end

`ifndef SYNTHESIS
  // Transmit-empty is never cleared in this model
  a_txempty_kept: assert property (@(posedge clk) disable iff (!rst_n)
    status_r[acia_pkg::ST_TXEMPTY])
    else $error("transmit-empty bit cleared");

  // Overrun can only stand while the receive register is full
  a_overrun_full: assert property (@(posedge clk) disable iff (!rst_n)
    status_r[acia_pkg::ST_OVERRUN] |-> status_r[acia_pkg::ST_RXFULL])
    else $error("overrun set with receive register empty");

  // Bits 5 and 6 of the status register are never set
  a_status_unused: assert property (@(posedge clk) disable iff (!rst_n)
    status_r[6:5] == 2'b00)
    else $error("unused status bits set");

  // A byte received with DTR off leaves the receive side untouched
  a_dtr_off_drop: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (item.op == acia_pkg::OP_RECEIVE) && !command_r[acia_pkg::CM_DTR]
    |=> $stable(receive_hold_r) && $stable(status_r))
    else $error("byte taken while DTR off");
`endif

endmodule

FILE: src/acia_serial_port_registers_top.sv
// A request accepted into the input register has its result put into the output register, which drives out_tdata.
// The block takes one request per cycle, sustained while out_tready stays high.
// A waiting result stalls the input only once the input register is also full; that
// register takes a new request whenever it is empty or its content moves on.
// Reset (rst_n low, synchronous) empties both stages and sets the registers to
// their power-up values: status 0x10, all others zero.
module acia_serial_port_registers_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data
  input  logic [2:0]  in_tuser,   // [0] op, [2:1] reg_select
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [0] tx_valid, [8:1] tx_byte, [16:9] status_now,
                                  // [24:17] rx_byte, [25] irq, [26] can_receive,
                                  // [43:27] baud_rate, [47:44] zero
);

  logic              in_valid_r;
  acia_pkg::item_t   in_item_r;
  logic              out_valid_r;
  acia_pkg::result_t out_result_r;
  acia_pkg::result_t result;
  logic              advance;
  logic              accept;

  // The held request moves on when the output register is free or being emptied
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r.data       <= in_tdata;
      in_item_r.op         <= acia_pkg::op_t'(in_tuser[0]);
      in_item_r.reg_select <= acia_pkg::reg_sel_t'(in_tuser[2:1]);
    end
  end

  acia_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .result  (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_result_r};

endmodule

FILE: tb/sv/acia_result_watch.sv
`timescale 1ns / 1ps

// Watches both channels of the serial port register block. Every accepted
// request is run through a local model of the registers. Every accepted
// result is compared with the oldest prediction.
module acia_result_watch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int          mismatches,
  output int          outstanding
);

  // Rate selected by the low nibble of the control register.
  logic [acia_pkg::BAUD_W-1:0] rate_by_sel [16] = '{
    17'd115200, 17'd50, 17'd75, 17'd110, 17'd134, 17'd150, 17'd300, 17'd600,
    17'd1200, 17'd1800, 17'd2400, 17'd3600, 17'd4800, 17'd7200, 17'd9600, 17'd19200
  };

  // Local copy of the register state.
  logic [7:0] rx_hold;
  logic [7:0] status_q;
  logic [7:0] command_q;
  logic [7:0] control_q;

  acia_pkg::result_t awaited_results [$];
  int                fail_count = 0;

  // The interrupt bit follows receive-full or transmit-empty, each under its
  // own enable in the command register.
  function automatic void update_irq();
    status_q[acia_pkg::ST_IRQ] =
      (status_q[acia_pkg::ST_RXFULL] && !command_q[acia_pkg::CM_RXIRQOFF]) ||
      (status_q[acia_pkg::ST_TXEMPTY] &&
       command_q[acia_pkg::CM_TXCTL_LO +: 2] == acia_pkg::TXCTL_IRQ_ON);
  endfunction

  // Applies one request to the local registers and returns the result it causes.
  function automatic acia_pkg::result_t predict_acia_step(input acia_pkg::op_t op,
                                                          input acia_pkg::reg_sel_t sel,
                                                          input logic [7:0] value);
    acia_pkg::result_t r;
    r = '0;
    if (op == acia_pkg::OP_WRITE) begin
      case (sel)
        acia_pkg::REG_DATA: begin
          // The byte leaves at once, so transmit-empty stays set.
          r.tx_valid = 1'b1;
          r.tx_byte  = value;
          status_q[acia_pkg::ST_TXEMPTY] = 1'b1;
          update_irq();
        end
        acia_pkg::REG_STATUS: begin
          // Programmed reset of the status flags; the value is ignored.
          status_q[acia_pkg::ST_IRQ]     = 1'b0;
          status_q[acia_pkg::ST_OVERRUN] = 1'b0;
          status_q[acia_pkg::ST_PARITY]  = 1'b0;
          status_q[acia_pkg::ST_FRAMING] = 1'b0;
          status_q[acia_pkg::ST_RXFULL]  = 1'b0;
          status_q[acia_pkg::ST_TXEMPTY] = 1'b1;
          update_irq();
        end
        acia_pkg::REG_COMMAND: begin
          command_q = value;
          update_irq();
        end
        default: begin
          // The control register does not touch the interrupt bit.
          control_q = value;
        end
      endcase
    end else if (command_q[acia_pkg::CM_DTR]) begin
      // A byte arriving on a full register raises overrun and replaces the old one.
      if (status_q[acia_pkg::ST_RXFULL]) status_q[acia_pkg::ST_OVERRUN] = 1'b1;
      rx_hold = value;
      status_q[acia_pkg::ST_RXFULL] = 1'b1;
      if (command_q[acia_pkg::CM_ECHO]) begin
        r.tx_valid = 1'b1;
        r.tx_byte  = value;
      end
      update_irq();
    end
    r.status_now  = status_q;
    r.rx_byte     = rx_hold;
    r.irq         = status_q[acia_pkg::ST_IRQ];
    r.can_receive = command_q[acia_pkg::CM_DTR] && !status_q[acia_pkg::ST_RXFULL];
    r.baud_rate   = rate_by_sel[control_q[3:0]];
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Results are checked before the request of the same edge is predicted; a request
  // passes the input and output registers first, so they can never belong together.
  always @(posedge clk) begin
    acia_pkg::result_t seen;
    acia_pkg::result_t want;
    if (!rst_n) begin
      rx_hold   = 8'h00;
      status_q  = acia_pkg::STATUS_RESET;
      command_q = 8'h00;
      control_q = 8'h00;
      awaited_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = acia_pkg::result_t'(out_tdata[$bits(acia_pkg::result_t)-1:0]);
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("tx_valid", 32'(want.tx_valid), 32'(seen.tx_valid));
          check_field("tx_byte", 32'(want.tx_byte), 32'(seen.tx_byte));
          check_field("status_now", 32'(want.status_now), 32'(seen.status_now));
          check_field("rx_byte", 32'(want.rx_byte), 32'(seen.rx_byte));
          check_field("irq", 32'(want.irq), 32'(seen.irq));
          check_field("can_receive", 32'(want.can_receive), 32'(seen.can_receive));
          check_field("baud_rate", 32'(want.baud_rate), 32'(seen.baud_rate));
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(predict_acia_step(acia_pkg::op_t'(in_tuser[0]),
                                                    acia_pkg::reg_sel_t'(in_tuser[2:1]),
                                                    in_tdata));
      end
    end
    mismatches  <= fail_count;
    outstanding <= awaited_results.size();
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_REQUESTS = 1550;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES = 150;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  int          mismatches;
  int          outstanding;

  acia_serial_port_registers_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  acia_result_watch result_watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one request and holds it until the block takes it. The valid is left
  // high so that a following request goes out back to back.
  task automatic send_request(input acia_pkg::op_t op, input acia_pkg::reg_sel_t sel,
                              input logic [7:0] value);
    in_tvalid <= 1'b1;
    in_tuser  <= {sel, op};
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stops sending until every predicted result has been taken.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random traffic weighted towards the paths that matter: DTR is usually
  // switched on so that received bytes are latched, overrun and echo occur,
  // and status resets come often enough to empty the receive register again.
  task automatic send_random_request();
    int unsigned roll;
    logic [7:0]  value;
    roll  = $urandom_range(0, 99);
    value = 8'($urandom_range(0, 255));
    if (roll < 12) begin
      if ($urandom_range(0, 3) != 0) value[acia_pkg::CM_DTR] = 1'b1;
      send_request(acia_pkg::OP_WRITE, acia_pkg::REG_COMMAND, value);
    end else if (roll < 20) begin
      send_request(acia_pkg::OP_WRITE, acia_pkg::REG_CONTROL, value);
    end else if (roll < 28) begin
      send_request(acia_pkg::OP_WRITE, acia_pkg::REG_STATUS, value);
    end else if (roll < 53) begin
      send_request(acia_pkg::OP_WRITE, acia_pkg::REG_DATA, value);
    end else begin
      send_request(acia_pkg::OP_RECEIVE, acia_pkg::reg_sel_t'($urandom_range(0, 3)), value);
    end
  endtask

  // Request side: reset, a directed opening, then random traffic.
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tuser  <= 3'b000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // A byte with DTR off is dropped.
    send_request(acia_pkg::OP_RECEIVE, acia_pkg::REG_CONTROL, 8'hA5);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_DATA, 8'h00);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_DATA, 8'hFF);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_CONTROL, 8'h0F);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_CONTROL, 8'h0A);
    // DTR on with the receive interrupt enabled, then a full register overruns.
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_COMMAND, 8'h01);
    send_request(acia_pkg::OP_RECEIVE, acia_pkg::REG_DATA, 8'h00);
    send_request(acia_pkg::OP_RECEIVE, acia_pkg::REG_COMMAND, 8'hFF);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_STATUS, 8'hFF);
    // Echo with the receive interrupt disabled.
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_COMMAND, 8'h13);
    send_request(acia_pkg::OP_RECEIVE, acia_pkg::REG_STATUS, 8'h5A);
    // Transmit control 01 raises the interrupt from transmit-empty, 11 does not.
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_COMMAND, 8'h05);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_DATA, 8'h81);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_COMMAND, 8'h0D);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_COMMAND, 8'hFF);
    send_request(acia_pkg::OP_RECEIVE, acia_pkg::REG_CONTROL, 8'h7E);
    send_request(acia_pkg::OP_RECEIVE, acia_pkg::REG_DATA, 8'h81);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_STATUS, 8'h00);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_CONTROL, 8'hFF);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_CONTROL, 8'h00);
    send_request(acia_pkg::OP_WRITE, acia_pkg::REG_COMMAND, 8'h00);
    send_request(acia_pkg::OP_RECEIVE, acia_pkg::REG_DATA, 8'h33);
    wait_drained();

    // Every third block of a hundred requests goes out without gaps.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      send_random_request();
      if (i % 300 == 299) wait_drained();
      else if ((i / 100) % 3 != 1) idle_gap(pick_gap());
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  // Result side: stretches of random stalls, stretches always ready, and now
  // and then a long hold-off that fills the block and stalls its input.
  initial begin
    int stretch;
    stretch = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stretch++;
      if (stretch % 20 == 4) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        repeat ($urandom_range(5, 15)) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 6)) @(posedge clk);
          out_tready <= 1'b0;
          repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3))
            @(posedge clk);
        end
      end
    end
  end

  // Ends the run when neither channel has moved a request or result for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("testbench NOT OK");
    $finish;
  end

endmodule
